// ===== sv/potl_pkg.sv =====
// potl_pkg: shared types and codes for the priority ordered task table
// entry layout, command, result and status codes, cell control struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package potl_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_UPDATE   = 3'd2,
        CMD_SEARCH   = 3'd3,
        CMD_COMPLETE = 3'd4,
        CMD_LIST     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_FULL      = 2'd2
    } res_code_t;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_INPROG  = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [1:0]  status;
        logic [22:0] deadline;
    } entry_t;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_INSERT,
        COP_REMOVE,
        COP_COMPLETE,
        COP_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic        latch;
        logic [15:0] key;
        entry_t      new_entry;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS,
        S_LIST
    } state_t;

endpackage

`default_nettype wire

// ===== sv/potl_req_if.sv =====
// potl_req_if: request channel of the priority ordered task table
// valid/ready handshake with command payload, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface potl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
    logic [1:0]  status_in;
    logic [22:0] deadline;
    logic [22:0] current_date;

    modport source (
        output valid, command, task_id, priority_req, status_in, deadline, current_date,
        input  ready
    );
    modport sink (
        input  valid, command, task_id, priority_req, status_in, deadline, current_date,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/potl_rsp_if.sv =====
// potl_rsp_if: result channel of the priority ordered task table
// valid/ready handshake with result payload, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface potl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_code;
    logic        found;
    logic [15:0] entry_id;
    logic [7:0]  entry_priority;
    logic [1:0]  entry_status;
    logic [22:0] entry_deadline;
    logic        last;

    modport source (
        output valid, result_code, found, entry_id, entry_priority, entry_status,
               entry_deadline, last,
        input  ready
    );
    modport sink (
        input  valid, result_code, found, entry_id, entry_priority, entry_status,
               entry_deadline, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/priority_ordered_task_table_top.sv =====
// priority_ordered_task_table_top: sorted task table built as a chain of cells
// channels: req (potl_req_if sink), rsp (potl_rsp_if source)
// uses potl_pkg, potl_cell
//
// usage:
//   each request on req carries one command: insert, remove, update, search,
//   complete or list overdue. every command answers on rsp with one or more
//   result items, the final one marked by last.
//   req.ready is high only while the sequencer is idle; one request is in
//   work at a time. a request is taken at any edge where valid and ready are
//   both high.
//   steps: the id compare is latched in every cell as the request is taken,
//   then S_EXEC shifts or updates the chain for insert, remove and complete,
//   and answers search and unknown codes; update adds an S_REINS step (remove,
//   then reinsert). list overdue rotates the chain once per stored entry in
//   S_LIST; the head cell is checked on each step.
//   stalls: results go out through one output register; while it holds an
//   unaccepted result the chain holds and no further result is produced.
//   reset: clears the fill count and the sequencer; entry contents are not
//   cleared, a slot counts only below the fill count.
`timescale 1ns / 1ps
`default_nettype none

module priority_ordered_task_table_top
    import potl_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    potl_req_if.sink   req,
    potl_rsp_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef struct packed {
        res_code_t code;
        logic      found;
        entry_t    entry;
        logic      last;
    } result_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    cmd_t          cmd_reg;
    entry_t        req_entry_reg;
    logic [22:0]   date_reg;
    entry_t        cap_reg, cap_next;
    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    cell_ctrl_t    ctrl;
    cell_op_t      op;
    entry_t        cell_entry [CAPACITY];
    entry_t        cell_sel   [CAPACITY];
    logic          cell_keep  [CAPACITY];
    logic          cell_pref  [CAPACITY];
    entry_t        sel_entry;
    logic          hit;
    logic          accept;
    logic          out_free;
    logic [1:0]    status_clean;
    entry_t        head;

    assign accept       = req.valid && req.ready;
    assign req.ready    = (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || rsp.ready;
    assign status_clean = (req.status_in == ST_BAD) ? ST_PENDING : req.status_in;
    assign hit          = cell_pref[CAPACITY-1];
    assign head         = cell_entry[0];

    always_comb
    begin
        ctrl.op        = op;
        ctrl.latch     = accept;
        ctrl.key       = req.task_id;
        ctrl.new_entry = req_entry_reg;
        if (state_reg == S_REINS)
        begin
            ctrl.new_entry.id       = cap_reg.id;
            ctrl.new_entry.deadline = cap_reg.deadline;
        end
    end

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_entry = sel_entry | cell_sel[i];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_k, pref_in;

        if (g == 0)
        begin : g_head
            assign left_e  = ctrl.new_entry;
            assign left_k  = 1'b1;
            assign pref_in = 1'b0;
        end
        else
        begin : g_body
            assign left_e  = cell_entry[g-1];
            assign left_k  = cell_keep[g-1];
            assign pref_in = cell_pref[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[g+1];
        end

        potl_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .count       (count_reg),
            .ctrl        (ctrl),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .head_entry  (head),
            .prefix_in   (pref_in),
            .entry       (cell_entry[g]),
            .keep        (cell_keep[g]),
            .prefix_out  (cell_pref[g]),
            .sel_entry   (cell_sel[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cap_next       = cap_reg;
        op             = COP_HOLD;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{code: RES_OK, found: 1'b0, entry: '0, last: 1'b1};
                    state_next     = S_IDLE;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (count_reg == CAP)
                            begin
                                out_next.code = RES_FULL;
                            end
                            else
                            begin
                                op         = COP_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_REMOVE, CMD_UPDATE, CMD_SEARCH, CMD_COMPLETE:
                        begin
                            if (!hit)
                            begin
                                out_next.code = RES_NOT_FOUND;
                            end
                            else
                            begin
                                case (cmd_reg)
                                    CMD_REMOVE:
                                    begin
                                        op         = COP_REMOVE;
                                        count_next = count_reg - CW'(1);
                                    end
                                    CMD_UPDATE:
                                    begin
                                        op             = COP_REMOVE;
                                        count_next     = count_reg - CW'(1);
                                        cap_next       = sel_entry;
                                        out_valid_next = out_valid_reg && !rsp.ready;
                                        out_next       = out_reg;
                                        state_next     = S_REINS;
                                    end
                                    CMD_SEARCH:
                                    begin
                                        out_next.found = 1'b1;
                                        out_next.entry = sel_entry;
                                    end
                                    default:
                                    begin
                                        op = COP_COMPLETE;
                                    end
                                endcase
                            end
                        end
                        CMD_LIST:
                        begin
                            out_valid_next = out_valid_reg && !rsp.ready;
                            out_next       = out_reg;
                            scan_next      = '0;
                            state_next     = S_LIST;
                        end
                        default:
                        begin
                            out_next.code = RES_OK;
                        end
                    endcase
                end
            end
            S_REINS:
            begin
                if (out_free)
                begin
                    op             = COP_INSERT;
                    count_next     = count_reg + CW'(1);
                    out_valid_next = 1'b1;
                    out_next       = '{code: RES_OK, found: 1'b0, entry: '0, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    if (scan_reg != count_reg)
                    begin
                        op        = COP_ROTATE;
                        scan_next = scan_reg + CW'(1);
                        if ((head.status == ST_INPROG) && (head.deadline < date_reg))
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{code: RES_OK, found: 1'b1, entry: head,
                                               last: 1'b0};
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{code: RES_OK, found: 1'b0, entry: '0, last: 1'b1};
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        cap_reg <= cap_next;
        if (accept)
        begin
            cmd_reg                <= cmd_t'(req.command);
            req_entry_reg.id       <= req.task_id;
            req_entry_reg.prio     <= req.priority_req;
            req_entry_reg.status   <= status_clean;
            req_entry_reg.deadline <= req.deadline;
            date_reg               <= req.current_date;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_code    = out_reg.code;
    assign rsp.found          = out_reg.found;
    assign rsp.entry_id       = out_reg.entry.id;
    assign rsp.entry_priority = out_reg.entry.prio;
    assign rsp.entry_status   = out_reg.entry.status;
    assign rsp.entry_deadline = out_reg.entry.deadline;
    assign rsp.last           = out_reg.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("fill count above capacity");

    a_reins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REINS) |-> (count_reg < CAP))
        else $error("reinsert without a free slot");

    a_list_items: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (state_reg == S_LIST))
        else $error("non-final result outside overdue listing");

endmodule

`default_nettype wire

// ===== sv/potl_cell.sv =====
// potl_cell: one slot of the sorted table chain
// holds one entry, exchanges data with its neighbors; uses potl_pkg
`timescale 1ns / 1ps
`default_nettype none

module potl_cell
    import potl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [CW-1:0] count,
    input  wire cell_ctrl_t    ctrl,
    input  wire entry_t        left_entry,
    input  wire logic          left_keep,
    input  wire entry_t        right_entry,
    input  wire entry_t        head_entry,
    input  wire logic          prefix_in,
    output entry_t             entry,
    output logic               keep,
    output logic               prefix_out,
    output entry_t             sel_entry
);

    localparam logic [CW-1:0] POS = CW'(IDX);

    entry_t entry_reg, entry_next;
    logic   match_reg;
    logic   occ, tail, first;

    assign occ        = (POS < count);
    assign tail       = (POS == (count - CW'(1)));
    assign keep       = occ && (entry_reg.prio >= ctrl.new_entry.prio);
    assign prefix_out = prefix_in | match_reg;
    assign first      = match_reg & ~prefix_in;
    assign entry      = entry_reg;
    assign sel_entry  = first ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            COP_INSERT:
            begin
                if (!keep)
                begin
                    entry_next = left_keep ? ctrl.new_entry : left_entry;
                end
            end
            COP_REMOVE:
            begin
                if (prefix_out)
                begin
                    entry_next = right_entry;
                end
            end
            COP_COMPLETE:
            begin
                if (first)
                begin
                    entry_next.status = ST_DONE;
                end
            end
            COP_ROTATE:
            begin
                entry_next = tail ? head_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.latch)
        begin
            match_reg <= occ && (entry_reg.id == ctrl.key);
        end
    end

endmodule

`default_nettype wire
